// ===== rtl/core/ddpd_pkg.sv =====
// Shared types and constants for the differential-drive PD speed loop.
// Used by the controller, datapath, divider and top level; depends on nothing.

package ddpd_pkg;

   // Beat layouts, lowest field last in the declaration (lowest bits).
   typedef struct packed {
      logic [6:0]  pad;
      logic        restart;
      logic [11:0] front_right_level;
      logic [11:0] side_right_level;
      logic [11:0] side_left_level;
      logic [11:0] front_left_level;
      logic [31:0] right_count;
      logic [31:0] left_count;
   } req_item_type;

   typedef struct packed {
      logic        pad;
      logic        move_done;
      logic [31:0] turn_counts;
      logic [31:0] travel_counts;
      logic [10:0] right_drive;
      logic [10:0] left_drive;
   } rsp_item_type;

   localparam int REQ_W = $bits(req_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   // Configuration registers.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_LEFT_SPEED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_SPEED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRAVEL      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_MODE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_USE_WALL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SENSOR_DIV  = 3'd7;

   typedef struct packed {
      logic [15:0] left_speed_setpoint;
      logic [15:0] right_speed_setpoint;
      logic [23:0] target_travel;
      logic        rotational_mode;
      logic        use_wall_sensors;
      logic [15:0] prop_gain;
      logic [15:0] deriv_gain;
      logic [15:0] sensor_divisor;
   } cfg_type;

   // Wall sensor thresholds.
   localparam logic [11:0] SIDE_CENTER       = 12'd2048;
   localparam logic [11:0] FRONT_WALL_LIMIT  = 12'd1024;
   localparam logic [11:0] SIDE_WALL_LIMIT   = 12'd1024;
   localparam logic [11:0] FRONT_ALIGN_LEVEL = 12'd2048;
   localparam logic [11:0] FRONT_STOP_LEVEL  = 12'd3000;

   // Drive saturation in per mille.
   localparam logic signed [31:0] DRIVE_LIMIT = 32'sd1000;

   // Alignment error magnitude and the divider that scales it.
   localparam int ALIGN_W   = 14;
   localparam int DIV_NUM_W = ALIGN_W - 1;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_ERR,
      ST_LP,
      ST_LD,
      ST_LS,
      ST_RP,
      ST_RD,
      ST_RS,
      ST_FIN
   } state_type;

   // Controller to datapath commands, one step of the tick each.
   typedef struct packed {
      logic capture;
      logic div_step;
      logic err_calc;
      logic left_prop;
      logic left_deriv;
      logic left_sum;
      logic right_prop;
      logic right_deriv;
      logic right_sum;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic use_wall;
   } stat_type;

endpackage

// ===== rtl/core/differential_drive_pd_speed_loop.sv =====
// Top level of the differential-drive incremental PD speed loop.
// Holds the configuration registers; depends on ddpd_pkg, ddpd_ctrl and ddpd_dp.

// One request beat is one control tick: the two absolute encoder counts, the
// four wall sensor levels and a restart flag. Each tick yields exactly one
// response beat with both wheel drives (per mille, saturated to +-1000), the
// half-sum travel and half-difference turn in counts, and the end-of-move
// flag. When wall alignment is on, a tick also runs the alignment divider,
// which retires one quotient bit per cycle. The other steps of a tick are
// set by the single shared 17x33 multiplier, which forms the proportional
// and derivative terms of each wheel in turn. The response sits in an
// output register, so the next tick is accepted while it waits; the block
// stalls only if a second result is ready before the first is taken.
// Configuration is written through csr_we, csr_index and csr_wdata, and
// should only be changed between ticks.

module differential_drive_pd_speed_loop (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata, lowest bit up: left_count[31:0], right_count[63:32],
   // front_left_level[75:64], side_left_level[87:76],
   // side_right_level[99:88], front_right_level[111:100], restart[112]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ddpd_pkg::REQ_W-1:0]           req_tdata,
   // rsp_tdata, lowest bit up: left_drive[10:0], right_drive[21:11],
   // travel_counts[53:22], turn_counts[85:54], move_done[86]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ddpd_pkg::RSP_W-1:0]           rsp_tdata,
   input  logic                                 csr_we,
   input  logic [ddpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ddpd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ddpd_pkg::cfg_type  cfg_ff, cfg_in;
   ddpd_pkg::cmd_type  cmd;
   ddpd_pkg::stat_type stat;

   // Register writes; bits above a register's width are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ddpd_pkg::REG_LEFT_SPEED:  cfg_in.left_speed_setpoint  = csr_wdata[15:0];
            ddpd_pkg::REG_RIGHT_SPEED: cfg_in.right_speed_setpoint = csr_wdata[15:0];
            ddpd_pkg::REG_TRAVEL:      cfg_in.target_travel        = csr_wdata[23:0];
            ddpd_pkg::REG_ROT_MODE:    cfg_in.rotational_mode      = csr_wdata[0];
            ddpd_pkg::REG_USE_WALL:    cfg_in.use_wall_sensors     = csr_wdata[0];
            ddpd_pkg::REG_PROP_GAIN:   cfg_in.prop_gain            = csr_wdata[15:0];
            ddpd_pkg::REG_DERIV_GAIN:  cfg_in.deriv_gain           = csr_wdata[15:0];
            ddpd_pkg::REG_SENSOR_DIV:  cfg_in.sensor_divisor       = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Everything resets to zero except the sensor divisor, which resets to one.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sensor_divisor: 16'd1, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ddpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ddpd_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg_ff),
      .req_data (req_tdata),
      .stat     (stat),
      .rsp_data (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // Once a tick is taken, the sequencer is busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a tick was in progress");

   // A new result appears only as a tick's work completes, never from idle.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised without a tick in progress");

   // Drives stay inside the per-mille limit.
   a_left_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[10:0]) <= 11'sd1000 &&
                      $signed(rsp_tdata[10:0]) >= -11'sd1000))
      else $error("left drive out of range");

   a_right_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[21:11]) <= 11'sd1000 &&
                      $signed(rsp_tdata[21:11]) >= -11'sd1000))
      else $error("right drive out of range");
`endif

endmodule

// ===== rtl/core/ddpd_div.sv =====
// Restoring divider for the wall alignment error, one quotient bit per step.
// Depends on ddpd_pkg for the operand widths.

module ddpd_div (
   input  logic                               clock,
   input  logic                               start,
   input  logic                               step,
   input  logic [ddpd_pkg::DIV_NUM_W-1:0]     numer,
   input  logic [ddpd_pkg::DIV_DEN_W-1:0]     denom,
   output logic [ddpd_pkg::DIV_NUM_W-1:0]     quot
);

   logic [ddpd_pkg::DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [ddpd_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [ddpd_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [ddpd_pkg::DIV_DEN_W:0]   trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      trial  = {rem_ff, quo_ff[ddpd_pkg::DIV_NUM_W-1]};
      if (start) begin
         rem_in = '0;
         quo_in = numer;
         // A zero divisor behaves as one.
         den_in = (denom == '0) ? ddpd_pkg::DIV_DEN_W'(1) : denom;
      end else if (step) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = ddpd_pkg::DIV_DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[ddpd_pkg::DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ddpd_pkg::DIV_DEN_W-1:0];
            quo_in = {quo_ff[ddpd_pkg::DIV_NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quot = quo_ff;

endmodule

// ===== rtl/core/ddpd_ctrl.sv =====
// Sequencer for one control tick: capture, divide (with wall sensors only), error, PD multiply steps, finish.
// Depends on ddpd_pkg for the state, command and status types.

module ddpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ddpd_pkg::stat_type   stat,
   output ddpd_pkg::cmd_type    cmd
);

   ddpd_pkg::state_type state_ff, state_in;
   logic [ddpd_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddpd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = stat.use_wall ? ddpd_pkg::ST_DIV : ddpd_pkg::ST_ERR;
            end
         end
         ddpd_pkg::ST_DIV: begin
            if (count_ff == ddpd_pkg::DIV_LAST) begin
               state_in = ddpd_pkg::ST_ERR;
            end
         end
         ddpd_pkg::ST_ERR: state_in = ddpd_pkg::ST_LP;
         ddpd_pkg::ST_LP:  state_in = ddpd_pkg::ST_LD;
         ddpd_pkg::ST_LD:  state_in = ddpd_pkg::ST_LS;
         ddpd_pkg::ST_LS:  state_in = ddpd_pkg::ST_RP;
         ddpd_pkg::ST_RP:  state_in = ddpd_pkg::ST_RD;
         ddpd_pkg::ST_RD:  state_in = ddpd_pkg::ST_RS;
         ddpd_pkg::ST_RS:  state_in = ddpd_pkg::ST_FIN;
         ddpd_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = ddpd_pkg::ST_IDLE;
            end
         end
         default: state_in = ddpd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ddpd_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ddpd_pkg::ST_DIV: cmd.div_step    = 1'b1;
         ddpd_pkg::ST_ERR: cmd.err_calc    = 1'b1;
         ddpd_pkg::ST_LP:  cmd.left_prop   = 1'b1;
         ddpd_pkg::ST_LD:  cmd.left_deriv  = 1'b1;
         ddpd_pkg::ST_LS:  cmd.left_sum    = 1'b1;
         ddpd_pkg::ST_RP:  cmd.right_prop  = 1'b1;
         ddpd_pkg::ST_RD:  cmd.right_deriv = 1'b1;
         ddpd_pkg::ST_RS:  cmd.right_sum   = 1'b1;
         ddpd_pkg::ST_FIN: cmd.finish      = out_free;
         default: ;
      endcase
   end

   always_comb begin
      count_in = '0;
      if (state_ff == ddpd_pkg::ST_DIV) begin
         count_in = count_ff + ddpd_pkg::DIV_CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddpd_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/ddpd_dp.sv =====
// Datapath of the PD speed loop: loop state, errors, shared multiplier, outputs.
// Depends on ddpd_pkg and instantiates ddpd_div.

module ddpd_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ddpd_pkg::cmd_type             cmd,
   input  ddpd_pkg::cfg_type             cfg,
   input  logic [ddpd_pkg::REQ_W-1:0]    req_data,
   output ddpd_pkg::stat_type            stat,
   output logic [ddpd_pkg::RSP_W-1:0]    rsp_data
);

   function automatic logic [31:0] sat_wide(input logic [51:0] v);
      logic [31:0] r;
      if (v[51:31] == {21{v[51]}}) begin
         r = v[31:0];
      end else begin
         r = v[51] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic [31:0] sat_err(input logic [33:0] v);
      logic [31:0] r;
      if (v[33:31] == {3{v[33]}}) begin
         r = v[31:0];
      end else begin
         r = v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic [10:0] sat_drive(input logic [31:0] v);
      logic [10:0] r;
      if ($signed(v) > ddpd_pkg::DRIVE_LIMIT) begin
         r = 11'(ddpd_pkg::DRIVE_LIMIT);
      end else if ($signed(v) < -ddpd_pkg::DRIVE_LIMIT) begin
         r = 11'(-ddpd_pkg::DRIVE_LIMIT);
      end else begin
         r = v[10:0];
      end
      return r;
   endfunction

   ddpd_pkg::req_item_type item;
   ddpd_pkg::rsp_item_type out_in, out_ff;

   // Loop state, cleared by reset; the restart flag clears the last errors and accumulators.
   logic [31:0] last_lc_ff, last_lc_in, last_rc_ff, last_rc_in;
   logic [31:0] last_el_ff, last_el_in, last_er_ff, last_er_in;
   logic [31:0] acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;

   // Per-tick working registers.
   logic [31:0] dl_ff, dl_in, dr_ff, dr_in;
   logic [31:0] travel_ff, travel_in, turn_ff, turn_in;
   logic        stop_ff, stop_in, neg_ff, neg_in, done_ff, done_in;
   logic [31:0] err_l_ff, err_l_in, err_r_ff, err_r_in;
   logic [49:0] prod_ff, prod_in;
   logic [51:0] sum_ff, sum_in;

   logic [31:0] last_lc_eff, last_rc_eff;
   logic [32:0] pair_sum, pair_diff, pair_sum_adj, pair_diff_adj;
   logic        front_low, side_l, side_r;
   logic [ddpd_pkg::ALIGN_W-1:0] fl_x, sl_x, sr_x, fr_x, align, align_mag;
   logic [ddpd_pkg::DIV_NUM_W-1:0] quot;
   logic [ddpd_pkg::ALIGN_W-1:0] fb;
   logic [33:0] el_wide, er_wide;
   logic [31:0] aturn, acc_r_next;
   logic signed [16:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [49:0] product;

   assign item = ddpd_pkg::req_item_type'(req_data);
   assign stat.use_wall = cfg.use_wall_sensors;

   // Alignment error from the raw sensor levels: one or both side walls, or the front pair.
   always_comb begin
      fl_x = {2'b00, item.front_left_level};
      sl_x = {2'b00, item.side_left_level};
      sr_x = {2'b00, item.side_right_level};
      fr_x = {2'b00, item.front_right_level};
      front_low = (item.front_left_level < ddpd_pkg::FRONT_WALL_LIMIT) &&
                  (item.front_right_level < ddpd_pkg::FRONT_WALL_LIMIT);
      side_l = item.side_left_level > ddpd_pkg::SIDE_WALL_LIMIT;
      side_r = item.side_right_level > ddpd_pkg::SIDE_WALL_LIMIT;
      align = '0;
      if (front_low) begin
         if (side_l && side_r) begin
            align = sl_x - sr_x;
         end else if (side_l) begin
            align = (sl_x - {2'b00, ddpd_pkg::SIDE_CENTER}) << 1;
         end else if (side_r) begin
            align = ({2'b00, ddpd_pkg::SIDE_CENTER} - sr_x) << 1;
         end
      end else if ((item.front_left_level > ddpd_pkg::FRONT_ALIGN_LEVEL) &&
                   (item.front_right_level > ddpd_pkg::FRONT_ALIGN_LEVEL)) begin
         align = fr_x - fl_x;
      end
      align_mag = align[ddpd_pkg::ALIGN_W-1] ? -align : align;
   end

   ddpd_div u_div (
      .clock (clock),
      .start (cmd.capture),
      .step  (cmd.div_step),
      .numer (align_mag[ddpd_pkg::DIV_NUM_W-1:0]),
      .denom (cfg.sensor_divisor),
      .quot  (quot)
   );

   always_comb begin
      last_lc_eff = item.restart ? '0 : last_lc_ff;
      last_rc_eff = item.restart ? '0 : last_rc_ff;
      pair_sum  = {item.left_count[31], item.left_count} +
                  {item.right_count[31], item.right_count};
      pair_diff = {item.right_count[31], item.right_count} -
                  {item.left_count[31], item.left_count};
      // Halving that truncates toward zero: round negative odd values up first.
      pair_sum_adj  = pair_sum + {32'd0, pair_sum[32]};
      pair_diff_adj = pair_diff + {32'd0, pair_diff[32]};

      fb = '0;
      if (cfg.use_wall_sensors) begin
         fb = neg_ff ? -{1'b0, quot} : {1'b0, quot};
      end
      el_wide = {{20{fb[13]}}, fb} +
                {{18{cfg.left_speed_setpoint[15]}}, cfg.left_speed_setpoint} -
                {{2{dl_ff[31]}}, dl_ff};
      er_wide = -{{20{fb[13]}}, fb} +
                {{18{cfg.right_speed_setpoint[15]}}, cfg.right_speed_setpoint} -
                {{2{dr_ff[31]}}, dr_ff};
      aturn = turn_ff[31] ? -turn_ff : turn_ff;

      mul_a = (cmd.left_prop || cmd.right_prop) ? $signed({1'b0, cfg.prop_gain}) :
                                                  $signed({1'b0, cfg.deriv_gain});
      if (cmd.left_prop) begin
         mul_b = $signed({err_l_ff[31], err_l_ff});
      end else if (cmd.left_deriv) begin
         mul_b = $signed({err_l_ff[31], err_l_ff} - {last_el_ff[31], last_el_ff});
      end else if (cmd.right_prop) begin
         mul_b = $signed({err_r_ff[31], err_r_ff});
      end else begin
         mul_b = $signed({err_r_ff[31], err_r_ff} - {last_er_ff[31], last_er_ff});
      end
      product = mul_a * mul_b;
      acc_r_next = sat_wide(sum_ff);
   end

   always_comb begin
      last_lc_in = last_lc_ff;
      last_rc_in = last_rc_ff;
      last_el_in = last_el_ff;
      last_er_in = last_er_ff;
      acc_l_in   = acc_l_ff;
      acc_r_in   = acc_r_ff;
      if (cmd.capture) begin
         last_lc_in = item.left_count;
         last_rc_in = item.right_count;
         if (item.restart) begin
            last_el_in = '0;
            last_er_in = '0;
            acc_l_in   = '0;
            acc_r_in   = '0;
         end
      end
      if (cmd.right_prop) begin
         acc_l_in   = sat_wide(sum_ff);
         last_el_in = err_l_ff;
      end
      if (cmd.finish) begin
         acc_r_in   = acc_r_next;
         last_er_in = err_r_ff;
      end
   end

   always_comb begin
      dl_in     = dl_ff;
      dr_in     = dr_ff;
      travel_in = travel_ff;
      turn_in   = turn_ff;
      stop_in   = stop_ff;
      neg_in    = neg_ff;
      done_in   = done_ff;
      err_l_in  = err_l_ff;
      err_r_in  = err_r_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      out_in    = out_ff;
      if (cmd.capture) begin
         dl_in     = item.left_count - last_lc_eff;
         dr_in     = item.right_count - last_rc_eff;
         travel_in = pair_sum_adj[32:1];
         turn_in   = pair_diff_adj[32:1];
         stop_in   = (item.front_left_level > ddpd_pkg::FRONT_STOP_LEVEL) &&
                     (item.front_right_level > ddpd_pkg::FRONT_STOP_LEVEL);
         neg_in    = align[ddpd_pkg::ALIGN_W-1];
      end
      if (cmd.err_calc) begin
         err_l_in = sat_err(el_wide);
         err_r_in = sat_err(er_wide);
         if (cfg.rotational_mode) begin
            done_in = aturn >= {8'd0, cfg.target_travel};
         end else begin
            done_in = ($signed({travel_ff[31], travel_ff}) >=
                       $signed({9'd0, cfg.target_travel})) || stop_ff;
         end
      end
      if (cmd.left_prop || cmd.left_deriv || cmd.right_prop || cmd.right_deriv) begin
         prod_in = product;
      end
      if (cmd.left_prop) begin
         sum_in = {{20{acc_l_ff[31]}}, acc_l_ff};
      end else if (cmd.right_prop) begin
         sum_in = {{20{acc_r_ff[31]}}, acc_r_ff};
      end else if (cmd.left_deriv || cmd.left_sum || cmd.right_deriv || cmd.right_sum) begin
         sum_in = sum_ff + {{2{prod_ff[49]}}, prod_ff};
      end
      if (cmd.finish) begin
         out_in.pad           = 1'b0;
         out_in.move_done     = done_ff;
         out_in.turn_counts   = turn_ff;
         out_in.travel_counts = travel_ff;
         out_in.right_drive   = sat_drive(acc_r_next);
         out_in.left_drive    = sat_drive(acc_l_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_lc_ff <= '0;
         last_rc_ff <= '0;
         last_el_ff <= '0;
         last_er_ff <= '0;
         acc_l_ff   <= '0;
         acc_r_ff   <= '0;
      end else begin
         last_lc_ff <= last_lc_in;
         last_rc_ff <= last_rc_in;
         last_el_ff <= last_el_in;
         last_er_ff <= last_er_in;
         acc_l_ff   <= acc_l_in;
         acc_r_ff   <= acc_r_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff     <= dl_in;
      dr_ff     <= dr_in;
      travel_ff <= travel_in;
      turn_ff   <= turn_in;
      stop_ff   <= stop_in;
      neg_ff    <= neg_in;
      done_ff   <= done_in;
      err_l_ff  <= err_l_in;
      err_r_ff  <= err_r_in;
      prod_ff   <= prod_in;
      sum_ff    <= sum_in;
      out_ff    <= out_in;
   end

   assign rsp_data = out_ff;

endmodule
